// File: sv/mrhlp_pkg.sv
// mrhlp_pkg: shared types and constants for the min-range hop-limited path block.
// No dependencies.
package mrhlp_pkg;
    localparam int COORD_W = 14;
    localparam int RANGE_W = 11;
    localparam int STOPS_W = 11;
    localparam int DSQ_W = 30;   // dy^2+dx^2 with 14-bit deltas
    localparam int LIM_W = 28;   // 100*1500^2 = 225,000,000
    localparam logic [COORD_W-1:0] DEST_COORD = 14'd10000;
    localparam logic [RANGE_W-1:0] RANGE_HIGH = 11'd1500;

    typedef struct packed {
        logic [COORD_W-1:0] point_y;
        logic [COORD_W-1:0] point_x;
        logic               last_point;
    } point_t;

    // controller -> datapath commands
    typedef struct packed {
        logic load;        // write input point to store
        logic set_limit;   // compute limit for current mid (multi-cycle)
        logic trial_init;  // seed queue with origin, restart visited clear
        logic clear_step;  // clear one visited mark
        logic pop;         // read queue head
        logic chk_dest;    // compare head against destination
        logic scan_start;  // begin scanning store from entry 0
        logic scan_step;   // advance scan one entry
    } cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic limit_done;
        logic clear_done;
        logic queue_empty;
        logic budget_neg;
        logic dest_hit;
        logic scan_done;
    } stat_t;
endpackage

// File: sv/mrhlp_if.sv
// mrhlp_if: valid/ready channel interface with generic payload.
// Depends on nothing.
interface mrhlp_if #(parameter int W = 1) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: sv/mrhlp_datapath.sv
// mrhlp_datapath: waypoint store, walk queue, visited marks, distance unit.
// Depends on mrhlp_pkg.
module mrhlp_datapath #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  mrhlp_pkg::cmd_t                  cmd,
    input  logic [mrhlp_pkg::COORD_W-1:0]    in_y,
    input  logic [mrhlp_pkg::COORD_W-1:0]    in_x,
    input  logic [mrhlp_pkg::RANGE_W-1:0]    mid,
    input  logic [mrhlp_pkg::STOPS_W-1:0]    max_stops,
    input  logic [$clog2(MAX_POINTS+1)-1:0]  point_count,
    output mrhlp_pkg::stat_t                 stat
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int QD = MAX_POINTS + 1;
    localparam int QW = $clog2(QD + 1);
    localparam int BW = mrhlp_pkg::STOPS_W + 1;
    localparam int C = mrhlp_pkg::COORD_W;

    logic [2*C-1:0] store_mem [MAX_POINTS];
    logic [2*C+BW-1:0] queue_mem [QD];
    logic visited_mem [MAX_POINTS];

    logic [mrhlp_pkg::LIM_W-1:0] limit_reg;
    logic [21:0] sq_reg;
    logic [1:0] lim_ph_reg;
    logic [QW-1:0] head_reg, tail_reg;
    logic [C-1:0] cy_reg, cx_reg;
    logic signed [BW-1:0] cbud_reg;
    logic [CW-1:0] scan_reg;       // address issued
    logic [2*C-1:0] srd_reg;        // registered store read
    logic vrd_reg;                  // registered visited read, same address
    logic [AW-1:0] sidx_reg;       // index of srd_reg
    logic svalid_reg;
    logic [2*C+BW-1:0] qrd_reg;
    logic dest_hit_reg;
    logic [CW-1:0] clr_reg;        // visited clear pointer

    // distance of store read vs current point
    logic [C-1:0] dy, dx;
    logic [mrhlp_pkg::DSQ_W-1:0] dsq;
    logic link;
    logic [C-1:0] ddy, ddx;
    logic [mrhlp_pkg::DSQ_W-1:0] ddsq;

    always_comb
    begin
        dy = (srd_reg[2*C-1:C] > cy_reg) ? srd_reg[2*C-1:C] - cy_reg : cy_reg - srd_reg[2*C-1:C];
        dx = (srd_reg[C-1:0] > cx_reg) ? srd_reg[C-1:0] - cx_reg : cx_reg - srd_reg[C-1:0];
        dsq = 30'(dy * dy) + 30'(dx * dx);
        link = svalid_reg && !vrd_reg && (dsq <= {2'd0, limit_reg});
        ddy = (qrd_reg[2*C+BW-1:C+BW] > mrhlp_pkg::DEST_COORD)
            ? qrd_reg[2*C+BW-1:C+BW] - mrhlp_pkg::DEST_COORD
            : mrhlp_pkg::DEST_COORD - qrd_reg[2*C+BW-1:C+BW];
        ddx = (qrd_reg[C+BW-1:BW] > mrhlp_pkg::DEST_COORD)
            ? qrd_reg[C+BW-1:BW] - mrhlp_pkg::DEST_COORD
            : mrhlp_pkg::DEST_COORD - qrd_reg[C+BW-1:BW];
        ddsq = 30'(ddy * ddy) + 30'(ddx * ddx);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && point_count < CW'(MAX_POINTS))
        begin
            store_mem[point_count[AW-1:0]] <= {in_y, in_x};
        end
        srd_reg <= store_mem[scan_reg[AW-1:0]];
        // visited marks: cleared entry by entry at trial start, set on link
        if (cmd.clear_step && clr_reg < point_count)
        begin
            visited_mem[clr_reg[AW-1:0]] <= 1'b0;
        end
        else if (link)
        begin
            visited_mem[sidx_reg] <= 1'b1;
        end
        vrd_reg <= visited_mem[scan_reg[AW-1:0]];
        if (link && tail_reg < QW'(QD))
        begin
            queue_mem[tail_reg[$clog2(QD)-1:0]] <= {srd_reg, BW'(cbud_reg - BW'(1))};
        end
        else if (cmd.trial_init)
        begin
            queue_mem[0] <= {{2*C{1'b0}}, 1'b0, max_stops};
        end
        qrd_reg <= queue_mem[head_reg[$clog2(QD)-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= '0;
            sq_reg <= '0;
            lim_ph_reg <= '0;
            head_reg <= '0;
            tail_reg <= '0;
            cy_reg <= '0;
            cx_reg <= '0;
            cbud_reg <= '0;
            scan_reg <= '0;
            sidx_reg <= '0;
            svalid_reg <= 1'b0;
            clr_reg <= '0;
            dest_hit_reg <= 1'b0;
        end
        else
        begin
            // limit = 100*mid*mid, with mid*mid registered before the multiply by 100
            if (cmd.set_limit)
            begin
                lim_ph_reg <= 2'd1;
                sq_reg <= 22'(mid * mid);
            end
            else if (lim_ph_reg == 2'd1)
            begin
                limit_reg <= mrhlp_pkg::LIM_W'(sq_reg * 7'd100);
                lim_ph_reg <= 2'd2;
            end
            if (cmd.trial_init)
            begin
                clr_reg <= '0;
                head_reg <= '0;
                tail_reg <= QW'(1);
            end
            if (cmd.clear_step && clr_reg < point_count)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.pop)
            begin
                head_reg <= head_reg + 1'b1;
            end
            if (cmd.chk_dest)
            begin
                cy_reg <= qrd_reg[2*C+BW-1:C+BW];
                cx_reg <= qrd_reg[C+BW-1:BW];
                cbud_reg <= qrd_reg[BW-1:0];
                dest_hit_reg <= (ddsq <= {2'd0, limit_reg});
            end
            svalid_reg <= 1'b0;
            if (cmd.scan_start)
            begin
                scan_reg <= '0;
            end
            else if (cmd.scan_step && scan_reg < point_count)
            begin
                scan_reg <= scan_reg + 1'b1;
                sidx_reg <= scan_reg[AW-1:0];
                svalid_reg <= 1'b1;
            end
            if (link && tail_reg < QW'(QD))
            begin
                tail_reg <= tail_reg + 1'b1;
            end
        end
    end

    assign stat.limit_done = (lim_ph_reg == 2'd2) && !cmd.set_limit;
    assign stat.clear_done = (clr_reg >= point_count);
    assign stat.queue_empty = (head_reg >= tail_reg);
    assign stat.budget_neg = cbud_reg[BW-1];
    assign stat.dest_hit = dest_hit_reg;
    assign stat.scan_done = (scan_reg >= point_count) && !svalid_reg;

    a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg <= QW'(QD)) else $error("queue tail overflow");
    a_head_le_tail: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> head_reg < tail_reg) else $error("pop of empty queue");
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        svalid_reg |-> CW'(sidx_reg) < point_count) else $error("scan past point count");
endmodule

// File: sv/mrhlp_ctrl.sv
// mrhlp_ctrl: controller for loading, binary search and BFS sequencing.
// Depends on mrhlp_pkg.
module mrhlp_ctrl #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_last,
    output logic                             in_ready,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [mrhlp_pkg::RANGE_W-1:0]    out_range,
    output logic [mrhlp_pkg::RANGE_W-1:0]    mid,
    output logic [$clog2(MAX_POINTS+1)-1:0]  point_count,
    output mrhlp_pkg::cmd_t                  cmd,
    input  mrhlp_pkg::stat_t                 stat
);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int RW = mrhlp_pkg::RANGE_W + 1;
    localparam int SW = RW + 1;
    localparam logic signed [RW-1:0] ONE_S = RW'(1);

    typedef enum logic [3:0] {
        S_LOAD, S_MID, S_LIMIT, S_INIT, S_CLEAR, S_POP, S_READ, S_CHECK,
        S_SCAN, S_VERDICT, S_OUT
    } state_t;

    state_t state_reg;
    logic signed [RW-1:0] low_reg, high_reg;
    logic [mrhlp_pkg::RANGE_W-1:0] best_reg, mid_reg;
    logic [CW-1:0] count_reg;
    logic pass_reg;
    logic [1:0] wait_reg;
    logic signed [RW-1:0] mid_ext, mid_dec, mid_inc;
    logic signed [SW-1:0] sum_pass, sum_fail;
    logic accept;

    assign accept = in_valid && in_ready;
    assign in_ready = (state_reg == S_LOAD);
    assign out_valid = (state_reg == S_OUT);
    assign out_range = best_reg;
    assign mid = mid_reg;
    assign point_count = count_reg;

    // next bounds and midpoints, one bit wider so low+high cannot overflow
    assign mid_ext = $signed({1'b0, mid_reg});
    assign mid_dec = mid_ext - ONE_S;
    assign mid_inc = mid_ext + ONE_S;
    assign sum_pass = SW'(low_reg) + SW'(mid_dec);
    assign sum_fail = SW'(mid_inc) + SW'(high_reg);

    always_comb
    begin
        cmd = '0;
        cmd.load = accept;
        cmd.set_limit = (state_reg == S_MID);
        cmd.trial_init = (state_reg == S_INIT);
        cmd.clear_step = (state_reg == S_CLEAR);
        cmd.pop = (state_reg == S_POP) && !stat.queue_empty;
        cmd.chk_dest = (state_reg == S_READ) && (wait_reg == 2'd0);
        cmd.scan_start = (state_reg == S_CHECK);
        cmd.scan_step = (state_reg == S_SCAN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            low_reg <= '0;
            high_reg <= '0;
            best_reg <= '0;
            mid_reg <= '0;
            count_reg <= '0;
            pass_reg <= 1'b0;
            wait_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_LOAD:
                begin
                    if (accept)
                    begin
                        if (count_reg < CW'(MAX_POINTS))
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        if (in_last)
                        begin
                            low_reg <= '0;
                            high_reg <= RW'(mrhlp_pkg::RANGE_HIGH);
                            best_reg <= mrhlp_pkg::RANGE_HIGH;
                            mid_reg <= mrhlp_pkg::RANGE_HIGH >> 1;
                            state_reg <= S_MID;
                            pass_reg <= 1'b0;
                        end
                    end
                end
                S_MID:
                begin
                    state_reg <= S_LIMIT;
                end
                S_LIMIT:
                begin
                    if (stat.limit_done)
                    begin
                        state_reg <= S_INIT;
                    end
                end
                S_INIT:
                begin
                    state_reg <= S_CLEAR;
                end
                S_CLEAR:
                begin
                    if (stat.clear_done)
                    begin
                        state_reg <= S_POP;
                    end
                end
                S_POP:
                begin
                    wait_reg <= '0;
                    if (stat.queue_empty)
                    begin
                        pass_reg <= 1'b0;
                        state_reg <= S_VERDICT;
                    end
                    else
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_READ:
                begin
                    // queue head is registered on entry; chk_dest latches it while wait_reg is zero
                    wait_reg <= wait_reg + 1'b1;
                    if (wait_reg == 2'd1)
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (stat.budget_neg)
                    begin
                        state_reg <= S_POP;
                    end
                    else if (stat.dest_hit)
                    begin
                        pass_reg <= 1'b1;
                        state_reg <= S_VERDICT;
                    end
                    else
                    begin
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (stat.scan_done)
                    begin
                        state_reg <= S_POP;
                    end
                end
                S_VERDICT:
                begin
                    if (pass_reg)
                    begin
                        // trial reached: high = mid-1
                        if (mid_reg < best_reg)
                        begin
                            best_reg <= mid_reg;
                        end
                        high_reg <= mid_dec;
                        if (low_reg <= mid_dec)
                        begin
                            mid_reg <= sum_pass[mrhlp_pkg::RANGE_W:1];
                            state_reg <= S_MID;
                        end
                        else
                        begin
                            state_reg <= S_OUT;
                        end
                    end
                    else
                    begin
                        // failed trial: low = mid+1
                        low_reg <= mid_inc;
                        if (mid_inc <= high_reg)
                        begin
                            mid_reg <= sum_fail[mrhlp_pkg::RANGE_W:1];
                            state_reg <= S_MID;
                        end
                        else
                        begin
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        count_reg <= '0;
                        state_reg <= S_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    a_best_bound: assert property (@(posedge clk) disable iff (!rst_n)
        best_reg <= mrhlp_pkg::RANGE_HIGH) else $error("best out of range");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_POINTS)) else $error("count overflow");
    a_out_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> count_reg == '0) else $error("count not cleared");
endmodule

// File: sv/min_range_hop_limited_path.sv
// Top level: min-range hop-limited path search; uses mrhlp_pkg, mrhlp_if, ctrl, datapath.
// Loading: one waypoint per cycle into the store; in_ready stays high while loading.
// Search: up to 11 binary-search trials; each trial clears N visited marks, then every
// popped point within budget and not at the destination scans all N stored points one per cycle.
// Reset (rst_n, async low) clears control, point count and max_stops; visited marks
// are cleared at the start of every trial instead.
module min_range_hop_limited_path #(
    parameter int MAX_POINTS = 1024
) (
    input  logic clk,
    input  logic rst_n,
    mrhlp_if.sink   in_ch,
    mrhlp_if.sink   cfg_ch,
    mrhlp_if.source out_ch
);
    localparam int CW = $clog2(MAX_POINTS + 1);

    mrhlp_pkg::point_t pt;
    mrhlp_pkg::cmd_t cmd;
    mrhlp_pkg::stat_t stat;
    logic [mrhlp_pkg::RANGE_W-1:0] mid;
    logic [CW-1:0] point_count;
    logic [mrhlp_pkg::STOPS_W-1:0] max_stops_reg;
    logic in_ready;

    assign pt = mrhlp_pkg::point_t'(in_ch.data);
    assign in_ch.ready = in_ready;
    // config written only while idle is a rule for the user; the block does not enforce it
    assign cfg_ch.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_stops_reg <= '0;
        end
        else if (cfg_ch.valid)
        begin
            max_stops_reg <= cfg_ch.data[mrhlp_pkg::STOPS_W-1:0];
        end
    end

    mrhlp_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_last(pt.last_point), .in_ready(in_ready),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_range(out_ch.data),
        .mid(mid), .point_count(point_count), .cmd(cmd), .stat(stat)
    );

    mrhlp_datapath #(.MAX_POINTS(MAX_POINTS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .in_y(pt.point_y), .in_x(pt.point_x),
        .mid(mid), .max_stops(max_stops_reg), .point_count(point_count), .stat(stat)
    );
endmodule
